[hw/rtl/srst_pkg.sv]
package srst_pkg;

  localparam int unsigned SWEEP_STEPS_DEF = 200;
  localparam int unsigned STEP_W = 8;
  localparam int unsigned ROM_DEPTH = 1 << STEP_W;
  localparam int unsigned TRIG_W = 15;

  localparam logic [0:0] REG_RANGE_NEAR = 1'b0;
  localparam logic [0:0] REG_RANGE_FAR  = 1'b1;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = PI_Q30 / 64'd2;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_MUL,
    ST_FIN
  } state_t;

  // one entry per clamped step
  typedef struct packed {
    logic              cos_neg;
    logic [TRIG_W-1:0] sin_q15;
    logic [TRIG_W-1:0] cos_q15;
    logic [10:0]       tenths;
    logic [7:0]        deg_floor;
    logic [7:0]        deg_ceil;
  } rom_entry_t;

  function automatic logic [TRIG_W-1:0] to_q15(input longint v);
    longint r;
    r = 0;
    if (v >= 0) begin
      r = (v + 64'sd16384) >>> 15;
      if (r > 64'sd32767) begin
        r = 64'sd32767;
      end
    end
    return TRIG_W'(r);
  endfunction

  // Taylor series in Q30 over [0, pi/2]; every term truncated
  function automatic rom_entry_t make_entry(input logic [63:0] theta_in,
                                            input logic [10:0] tenths,
                                            input logic [7:0]  deg_floor,
                                            input logic [7:0]  deg_ceil);
    rom_entry_t  e;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint      ss;
    longint      cs;
    a = theta_in;
    e.cos_neg = 1'b0;
    if (theta_in > HALF_PI_Q30) begin
      a = PI_Q30 - theta_in;
      e.cos_neg = 1'b1;
    end
    a2 = (a * a) >> 30;
    ts = a;
    tc = ONE_Q30;
    ss = longint'(a);
    cs = longint'(ONE_Q30);
    ts = ((ts * a2) >> 30) / 64'd6;   tc = ((tc * a2) >> 30) / 64'd2;
    ss = ss - longint'(ts);           cs = cs - longint'(tc);
    ts = ((ts * a2) >> 30) / 64'd20;  tc = ((tc * a2) >> 30) / 64'd12;
    ss = ss + longint'(ts);           cs = cs + longint'(tc);
    ts = ((ts * a2) >> 30) / 64'd42;  tc = ((tc * a2) >> 30) / 64'd30;
    ss = ss - longint'(ts);           cs = cs - longint'(tc);
    ts = ((ts * a2) >> 30) / 64'd72;  tc = ((tc * a2) >> 30) / 64'd56;
    ss = ss + longint'(ts);           cs = cs + longint'(tc);
    ts = ((ts * a2) >> 30) / 64'd110; tc = ((tc * a2) >> 30) / 64'd90;
    ss = ss - longint'(ts);           cs = cs - longint'(tc);
    ts = ((ts * a2) >> 30) / 64'd156; tc = ((tc * a2) >> 30) / 64'd132;
    ss = ss + longint'(ts);           cs = cs + longint'(tc);
    ts = ((ts * a2) >> 30) / 64'd210; tc = ((tc * a2) >> 30) / 64'd182;
    ss = ss - longint'(ts);           cs = cs - longint'(tc);
    e.sin_q15 = to_q15(ss);
    e.cos_q15 = to_q15(cs);
    e.tenths = tenths;
    e.deg_floor = deg_floor;
    e.deg_ceil = deg_ceil;
    return e;
  endfunction

endpackage

[hw/rtl/srst_trig_rom.sv]
module srst_trig_rom
  import srst_pkg::*;
#(
  parameter int unsigned SWEEP_STEPS = SWEEP_STEPS_DEF
) (
  input  logic [STEP_W-1:0] addr,
  output rom_entry_t        data
);

  rom_entry_t rom_q [ROM_DEPTH];

  // entries at or above SWEEP_STEPS are never addressed (step is clamped)
  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_ent
    localparam logic [63:0] THETA = (64'(i) * PI_Q30) / 64'(SWEEP_STEPS);
    localparam logic [31:0] TENTHS = (32'(i) * 32'd1800) / 32'(SWEEP_STEPS);
    localparam logic [31:0] DEGF = (32'(i) * 32'd180) / 32'(SWEEP_STEPS);
    localparam logic [31:0] DEGC =
      (32'(i) * 32'd180 + 32'(SWEEP_STEPS) - 32'd1) / 32'(SWEEP_STEPS);
    assign rom_q[i] = make_entry(THETA, TENTHS[10:0], DEGF[7:0], DEGC[7:0]);
  end

  assign data = rom_q[addr];

endmodule

[hw/rtl/sweep_range_scan_tracker_core.sv]
// Sweep range scan tracker. Each input word (step, echo time, last flag) gives
// one output word: distance in Q8 cm, angle in tenths of a degree, a window
// hit flag, x/y in Q8 cm for hits, the running near/far and angle bounds and,
// on the last step, the obstacle verdict. All multiplies are bit-serial: the
// echo-to-distance product is formed first, then x and y in parallel, and
// the finish state loads the output register. in_ready stays low from an
// accept until the machine is back in idle, so a new word is taken only once
// the last is through; finish waits while the previous output word is untaken.
// A finished word sits in the output register while the next item is taken.
// Range window writes apply at once; the bound trackers pick them up at the
// next step zero.
module sweep_range_scan_tracker_core
  import srst_pkg::*;
#(
  parameter int unsigned SWEEP_STEPS = SWEEP_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [STEP_W-1:0]  step_index,
  input  logic [15:0]        echo_us,
  input  logic               last_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               point_valid,
  output logic signed [15:0] x_q8,
  output logic [14:0]        y_q8,
  output logic [18:0]        distance_q8,
  output logic [10:0]        angle_tenths,
  output logic               sweep_done,
  output logic               obstacle,
  output logic [10:0]        near_bound_cm,
  output logic [10:0]        far_bound_cm,
  output logic [7:0]         angle_low_deg,
  output logic [7:0]         angle_high_deg
);

  localparam int unsigned ECHO_W = 16;
  localparam int unsigned STEPS_BITS = $clog2(SWEEP_STEPS + 1);
  localparam int unsigned CMP_W = (STEPS_BITS > STEP_W) ? STEPS_BITS : STEP_W;
  localparam logic [10:0] DIST_K = 11'd1114;  // 0.017 cm/us in Q16

  state_t state, state_next;

  logic [9:0]  range_near, range_far;
  logic [10:0] far_track, near_track;
  logic [7:0]  angle_high_track, angle_low_track;

  logic [STEP_W-1:0] step_q;
  logic              last_q;
  logic [4:0]        cnt;
  logic [27:0]       dacc;   // {partial, echo shifting out}
  logic [34:0]       xacc;   // {partial, cos shifting out}
  logic [34:0]       yacc;

  rom_entry_t rom_data;

  logic accept, load_out, cnt_end;
  logic [STEP_W-1:0] step_clamp;

  srst_trig_rom #(
    .SWEEP_STEPS(SWEEP_STEPS)
  ) u_rom (
    .addr(step_q),
    .data(rom_data)
  );

  assign accept = in_valid && in_ready;
  assign step_clamp = (CMP_W'(step_index) >= CMP_W'(SWEEP_STEPS)) ?
                      STEP_W'(SWEEP_STEPS - 1) : step_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    load_out = 1'b0;
    cnt_end = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_DIST;
        end
      end
      ST_DIST: begin
        cnt_end = (cnt == 5'(ECHO_W - 1));
        if (cnt_end) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_end = (cnt == 5'(TRIG_W - 1));
        if (cnt_end) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // serial adders
  logic [11:0] dsum;
  logic [19:0] xsum, ysum;
  logic [18:0] dist_q8;

  assign dist_q8 = dacc[26:8];
  assign dsum = dacc[27:16] + (dacc[0] ? {1'b0, DIST_K} : 12'd0);
  assign xsum = xacc[34:15] + (xacc[0] ? {1'b0, dist_q8} : 20'd0);
  assign ysum = yacc[34:15] + (yacc[0] ? {1'b0, dist_q8} : 20'd0);

  always_ff @(posedge clk) begin
    if (accept) begin
      step_q <= step_clamp;
      last_q <= last_step;
      dacc <= {12'd0, echo_us};
      cnt <= '0;
    end
    if (state == ST_DIST) begin
      dacc <= {1'b0, dsum, dacc[15:1]};
      cnt <= cnt_end ? 5'd0 : cnt + 5'd1;
      if (cnt_end) begin
        xacc <= {20'd0, rom_data.cos_q15};
        yacc <= {20'd0, rom_data.sin_q15};
      end
    end
    if (state == ST_MUL) begin
      xacc <= {1'b0, xsum, xacc[14:1]};
      yacc <= {1'b0, ysum, yacc[14:1]};
      cnt <= cnt + 5'd1;
    end
  end

  // finish: window test, coordinates, trackers
  logic [10:0] dfloor, dceil;
  logic        hit;
  logic [19:0] xmag, ymag;
  logic [15:0] x_sat;
  logic [14:0] y_sat;
  logic [10:0] far_next, near_next;
  logic [7:0]  ahigh_next, alow_next;
  logic        obstacle_next;

  always_comb begin
    dfloor = dacc[26:16];
    dceil = dfloor + {10'd0, (dacc[15:8] != 8'd0)};
    hit = (dfloor >= {1'b0, range_near}) && (dceil <= {1'b0, range_far});
    // round half up: upper word plus the bit below it
    xmag = xacc[34:15] + {19'd0, xacc[14]};
    ymag = yacc[34:15] + {19'd0, yacc[14]};
    if (rom_data.cos_neg) begin
      x_sat = (xmag > 20'd32768) ? 16'h8000 : 16'(-xmag);
    end else begin
      x_sat = (xmag > 20'd32767) ? 16'h7fff : xmag[15:0];
    end
    y_sat = (ymag > 20'd32767) ? 15'h7fff : ymag[14:0];
    far_next = far_track;
    near_next = near_track;
    ahigh_next = angle_high_track;
    alow_next = angle_low_track;
    if (hit) begin
      if (far_track < dceil) far_next = dceil;
      if (near_track > dfloor) near_next = dfloor;
      if (angle_high_track < rom_data.deg_ceil) ahigh_next = rom_data.deg_ceil;
      if (angle_low_track > rom_data.deg_floor) alow_next = rom_data.deg_floor;
    end
    obstacle_next = last_q && (far_next > near_next) && (ahigh_next > alow_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_near <= 10'd20;
      range_far <= 10'd100;
      far_track <= 11'd20;
      near_track <= 11'd100;
      angle_high_track <= 8'd0;
      angle_low_track <= 8'd180;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RANGE_NEAR: range_near <= cfg_data;
          REG_RANGE_FAR:  range_far <= cfg_data;
          default: ;
        endcase
      end
      if (accept && (step_index == '0)) begin
        far_track <= {1'b0, range_near};
        near_track <= {1'b0, range_far};
        angle_high_track <= 8'd0;
        angle_low_track <= 8'd180;
      end
      if (load_out) begin
        far_track <= far_next;
        near_track <= near_next;
        angle_high_track <= ahigh_next;
        angle_low_track <= alow_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      point_valid <= hit;
      x_q8 <= hit ? x_sat : 16'sd0;
      y_q8 <= hit ? y_sat : 15'd0;
      distance_q8 <= dist_q8;
      angle_tenths <= rom_data.tenths;
      sweep_done <= last_q;
      obstacle <= obstacle_next;
      near_bound_cm <= near_next;
      far_bound_cm <= far_next;
      angle_low_deg <= alow_next;
      angle_high_deg <= ahigh_next;
    end
  end

endmodule

[hw/rtl/srst_checker.sv]
module srst_checker
  import srst_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               point_valid,
  input logic signed [15:0] x_q8,
  input logic [14:0]        y_q8,
  input logic [18:0]        distance_q8,
  input logic [10:0]        angle_tenths,
  input logic               sweep_done,
  input logic               obstacle,
  input logic [10:0]        near_bound_cm,
  input logic [10:0]        far_bound_cm,
  input logic [7:0]         angle_low_deg,
  input logic [7:0]         angle_high_deg
);

  // a word left untaken must stay, with its distance, angle and hit flag unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_q8)
                                && $stable(angle_tenths) && $stable(point_valid))
    else $error("output word dropped while stalled");

  // one item at a time: no accept on the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> (x_q8 == 16'sd0) && (y_q8 == 15'd0))
    else $error("coordinates nonzero on a miss");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && obstacle |-> sweep_done && (far_bound_cm > near_bound_cm)
                              && (angle_high_deg > angle_low_deg))
    else $error("obstacle verdict inconsistent with bounds");

endmodule

bind sweep_range_scan_tracker_core srst_checker u_srst_checker (.*);
